// ===== sv/tli_pkg.sv =====
// ----------------------------------------------------------------------------
// Table linear interpolator package
// Shared sizes, command codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package tli_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 7;
  localparam int DATA_W      = 32;
  localparam int FRAC_BITS   = 16;

  // Dividend is |q - x0| scaled by 2^16, so the quotient is 48 bits wide.
  localparam int DIV_STEPS   = DATA_W + FRAC_BITS;
  localparam int DIVC_W      = $clog2(DIV_STEPS);

  localparam int IN_W        = 104;
  localparam int OUT_W       = 80;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(64);
  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(TABLE_DEPTH);

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic              wr_en;
    logic              start;
    logic [ADDR_W-1:0] rd_addr;
    logic              seg_load;
    logic [ADDR_W-1:0] seg_idx;
    logic              lo_load;
    logic              hi_load;
    logic              div_step;
    logic              frac_load;
    logic              mul_load;
    logic              shift_load;
    logic              sum_load;
    logic              out_load;
  } tli_cmd_t;

  typedef struct packed {
    logic hit;
    logic den_zero;
  } tli_stat_t;

endpackage

// ===== sv/tli_ctrl.sv =====
// ----------------------------------------------------------------------------
// Table linear interpolator controller
// Sequences loads, the breakpoint scan, the divider and the output register.
// ----------------------------------------------------------------------------
module tli_ctrl
  import tli_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_command,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  tli_stat_t        stat,
  output tli_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCAN     = 4'd1;
  localparam logic [3:0] S_FETCH_LO = 4'd2;
  localparam logic [3:0] S_FETCH_HI = 4'd3;
  localparam logic [3:0] S_DIV      = 4'd4;
  localparam logic [3:0] S_FRAC     = 4'd5;
  localparam logic [3:0] S_MUL      = 4'd6;
  localparam logic [3:0] S_SHIFT    = 4'd7;
  localparam logic [3:0] S_SUM      = 4'd8;
  localparam logic [3:0] S_RESULT   = 4'd9;

  logic [3:0]        state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [DIVC_W-1:0] divc, divc_next;
  logic [CNT_W-1:0]  point_count;
  logic [CNT_W-1:0]  count_lim;
  logic              out_valid_next;

  assign count_lim = (point_count > COUNT_LIMIT) ? COUNT_LIMIT : point_count;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    divc_next  = divc;
    cmd        = '0;
    cmd.rd_addr = idx;
    cmd.seg_idx = idx;
    case (state)
      S_IDLE: begin
        cmd.rd_addr = ADDR_W'(1);
        if (in_valid) begin
          if (in_command == CMD_LOAD) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            idx_next   = ADDR_W'(1);
            state_next = (count_lim < CNT_W'(2)) ? S_RESULT : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.seg_load = 1'b1;
          cmd.rd_addr  = idx - ADDR_W'(1);
          state_next   = S_FETCH_LO;
        end else if (({1'b0, idx} + CNT_W'(1)) >= count_lim) begin
          state_next = S_RESULT;
        end else begin
          idx_next    = idx + ADDR_W'(1);
          cmd.rd_addr = idx + ADDR_W'(1);
        end
      end
      S_FETCH_LO: begin
        cmd.lo_load = 1'b1;
        state_next  = S_FETCH_HI;
      end
      S_FETCH_HI: begin
        cmd.hi_load = 1'b1;
        divc_next   = DIVC_W'(DIV_STEPS - 1);
        state_next  = stat.den_zero ? S_RESULT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (divc == '0) begin
          state_next = S_FRAC;
        end else begin
          divc_next = divc - DIVC_W'(1);
        end
      end
      S_FRAC: begin
        cmd.frac_load = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_next   = S_SHIFT;
      end
      S_SHIFT: begin
        cmd.shift_load = 1'b1;
        state_next     = S_SUM;
      end
      S_SUM: begin
        cmd.sum_load = 1'b1;
        state_next   = S_RESULT;
      end
      S_RESULT: begin
        // Wait here only while an earlier result is still unclaimed.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      divc        <= '0;
      out_valid   <= 1'b0;
      point_count <= COUNT_RESET;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      divc      <= divc_next;
      out_valid <= out_valid_next;
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end
    end
  end

`ifndef SYNTH
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx != '0 && {1'b0, idx} < count_lim))
    else $error("scan index outside the table range in use");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result overwrote an unclaimed result");

  a_div_to_frac: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && divc == '0) |=> (state == S_FRAC))
    else $error("divider did not hand over after its last step");

  a_query_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_command == CMD_QUERY) |=> (state != S_IDLE))
    else $error("query transfer did not start a query");
`endif

endmodule

// ===== sv/tli_dpath.sv =====
// ----------------------------------------------------------------------------
// Table linear interpolator datapath
// Table memories, scan compare, restoring divider, multiplier and saturation.
// ----------------------------------------------------------------------------
module tli_dpath
  import tli_pkg::*;
(
  input  logic             clk,
  input  tli_cmd_t         cmd,
  output tli_stat_t        stat,
  input  logic [IN_W-1:0]  in_data,
  output logic [OUT_W-1:0] out_data
);

  logic [ADDR_W-1:0]        entry_index;
  logic signed [DATA_W-1:0] breakpoint, table_value, query_position;

  assign entry_index    = in_data[5:0];
  assign breakpoint     = in_data[37:6];
  assign table_value    = in_data[69:38];
  assign query_position = in_data[101:70];

  logic [DATA_W-1:0] bp_mem  [TABLE_DEPTH];
  logic [DATA_W-1:0] val_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] bp_q, val_q;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      bp_mem[entry_index]  <= breakpoint;
      val_mem[entry_index] <= table_value;
    end
    bp_q  <= bp_mem[cmd.rd_addr];
    val_q <= val_mem[cmd.rd_addr];
  end

  logic signed [DATA_W-1:0] q_reg, x0, x1, v0, v1;
  logic [ADDR_W-1:0]        seg;
  logic                     found, fault, sat;
  logic signed [DATA_W:0]   num, den, num_mag, den_mag;

  assign num = {q_reg[DATA_W-1], q_reg} - {x0[DATA_W-1], x0};
  assign den = {x1[DATA_W-1], x1} - {x0[DATA_W-1], x0};
  assign num_mag = num[DATA_W] ? -num : num;
  assign den_mag = den[DATA_W] ? -den : den;

  assign stat.hit      = (bp_q >= q_reg);
  assign stat.den_zero = (x1 == x0);

  // Restoring divider on magnitudes, one quotient bit per step.
  logic [DATA_W-1:0]    rem, dvs;
  logic [DIV_STEPS-1:0] rq;
  logic                 qneg;
  logic [DATA_W:0]      trial;
  logic                 ge;

  assign trial = {rem, rq[DIV_STEPS-1]};
  assign ge    = (trial >= {1'b0, dvs});

  // Fraction saturation from the quotient magnitude.
  logic pos_over, neg_over;
  assign pos_over = !qneg && (rq[DIV_STEPS-1:DATA_W-1] != '0);
  assign neg_over = qneg && ((rq[DIV_STEPS-1:DATA_W] != '0) ||
                             (rq[DATA_W-1] && rq[DATA_W-2:0] != '0));

  logic signed [DATA_W-1:0]          frac, val_res;
  logic signed [DATA_W:0]            diff;
  logic signed [2*DATA_W:0]          prod;
  logic signed [2*DATA_W-FRAC_BITS:0] tq;
  logic                              rnd;
  logic signed [2*DATA_W-FRAC_BITS+1:0] sum;
  logic                              sum_hi, sum_lo;

  // Division by 2^16 truncates toward zero: bump negative inexact results.
  assign rnd = prod[2*DATA_W] && (prod[FRAC_BITS-1:0] != '0);
  assign sum = {{(DATA_W-FRAC_BITS+2){v0[DATA_W-1]}}, v0} + {tq[2*DATA_W-FRAC_BITS], tq};
  assign sum_hi = !sum[2*DATA_W-FRAC_BITS+1] && (sum[2*DATA_W-FRAC_BITS:DATA_W-1] != '0);
  assign sum_lo = sum[2*DATA_W-FRAC_BITS+1] && (sum[2*DATA_W-FRAC_BITS:DATA_W-1] != '1);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      q_reg   <= query_position;
      found   <= 1'b0;
      fault   <= 1'b0;
      sat     <= 1'b0;
      seg     <= '0;
      frac    <= '0;
      val_res <= '0;
    end
    if (cmd.seg_load) begin
      found <= 1'b1;
      seg   <= cmd.seg_idx;
      x1    <= bp_q;
    end
    if (cmd.lo_load) begin
      x0 <= bp_q;
      v0 <= val_q;
    end
    if (cmd.hi_load) begin
      v1    <= val_q;
      fault <= stat.den_zero;
      rem   <= '0;
      rq    <= {num_mag[DATA_W-1:0], FRAC_BITS'(0)};
      dvs   <= den_mag[DATA_W-1:0];
      qneg  <= num[DATA_W] ^ den[DATA_W];
    end
    if (cmd.div_step) begin
      rem <= ge ? DATA_W'(trial - {1'b0, dvs}) : trial[DATA_W-1:0];
      rq  <= {rq[DIV_STEPS-2:0], ge};
    end
    if (cmd.frac_load) begin
      diff <= {v1[DATA_W-1], v1} - {v0[DATA_W-1], v0};
      if (pos_over) begin
        frac <= {1'b0, {(DATA_W-1){1'b1}}};
      end else if (neg_over) begin
        frac <= {1'b1, {(DATA_W-1){1'b0}}};
      end else if (qneg) begin
        frac <= -rq[DATA_W-1:0];
      end else begin
        frac <= rq[DATA_W-1:0];
      end
      sat <= pos_over | neg_over;
    end
    if (cmd.mul_load) begin
      prod <= diff * frac;
    end
    if (cmd.shift_load) begin
      tq <= prod[2*DATA_W:FRAC_BITS] + {{(2*DATA_W-FRAC_BITS){1'b0}}, rnd};
    end
    if (cmd.sum_load) begin
      if (sum_hi) begin
        val_res <= {1'b0, {(DATA_W-1){1'b1}}};
      end else if (sum_lo) begin
        val_res <= {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        val_res <= sum[DATA_W-1:0];
      end
      sat <= sat | sum_hi | sum_lo;
    end
    if (cmd.out_load) begin
      out_data <= {7'd0, sat, val_res, frac, seg, fault, found};
    end
  end

endmodule

// ===== sv/table_linear_interpolator_core.sv =====
// A load is written to the table and gives no result; loads can follow back to back.
// A query scans from entry 1 for the first breakpoint at or above the query position, then
// fetches the segment ends, divides, then forms the fraction, product, shift and sum in turn.
// No match ends the scan at the last entry in use (point count limited to 64); a count below 2
// skips the scan; equal breakpoints skip the divider. The next item transfers once back in idle.
// Reset (rst, synchronous) empties the output and sets the point count to 64; table unset.
// ----------------------------------------------------------------------------
// Table linear interpolator core
// Piecewise linear interpolation over a loadable table of Q16.16 points.
// ----------------------------------------------------------------------------
module table_linear_interpolator_core
  import tli_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // entry_index, breakpoint, table_value, query_position, zero fill
  input  logic [IN_W-1:0]  s_axis_tdata,
  // command
  input  logic [0:0]       s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // found, divide_fault, segment_index, fraction, result_value, saturated, zero fill
  output logic [OUT_W-1:0] m_axis_tdata,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  tli_cmd_t  cmd;
  tli_stat_t stat;

  tli_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser[0]),
    .in_ready   (s_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .stat       (stat),
    .cmd        (cmd)
  );

  tli_dpath u_dpath (
    .clk      (clk),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (s_axis_tdata),
    .out_data (m_axis_tdata)
  );

endmodule
